FILE: hdl/cau_pkg.sv
// ---------------------------------------------------------------------------
// cau_pkg: shared types and constants of the complex arithmetic unit
// opcodes, default sizes and the control group that rides along the pipeline
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cau_pkg;

  // default operand width and fraction bits
  localparam int unsigned WidthDef = 16;
  localparam int unsigned FracDef  = 8;

  // operation codes
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  // control group carried from stage to stage
  typedef struct packed {
    logic vld;
    logic is_div;
    logic dz;
    logic neg_re;
    logic neg_im;
  } ctrl_t;

endpackage

FILE: hdl/cau_prep.sv
// ---------------------------------------------------------------------------
// cau_prep: operand front end
// stage one forms the six products and the add/sub sums, stage two forms
// the finished add/sub/mul results and the divide numerators and divisor
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cau_prep #(
  parameter int unsigned W = cau_pkg::WidthDef,
  parameter int unsigned F = cau_pkg::FracDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic [1:0]           opcode_i,
  input  logic [W-1:0]         a_re_i,
  input  logic [W-1:0]         a_im_i,
  input  logic [W-1:0]         b_re_i,
  input  logic [W-1:0]         b_im_i,
  output cau_pkg::ctrl_t       ctrl_o,
  output logic [2*W-1:0]       mag_re_o,
  output logic [2*W-1:0]       mag_im_o,
  output logic [2*W-1:0]       den_o,
  output logic [W-1:0]         res_re_o,
  output logic [W-1:0]         res_im_o
);
  import cau_pkg::*;

  localparam int unsigned PW = 2 * W;

  // stage one registers
  logic                 vld1_q;
  op_e                  op1_q;
  logic signed [PW-1:0] ac_q, ad_q, bc_q, bd_q, cc_q, dd_q;
  logic signed [W:0]    sum_re_q, sum_im_q;

  // stage two registers
  ctrl_t          ctrl_q, ctrl_d;
  logic [PW-1:0]  mag_re_q, mag_re_d, mag_im_q, mag_im_d, den_q, den_d;
  logic [W-1:0]   res_re_q, res_re_d, res_im_q, res_im_d;

  logic signed [PW:0] mre, mim, nre, nim;
  logic [PW-1:0]      mul_re_mag, mul_im_mag;

  // magnitude of a wide signed value
  function automatic logic [PW-1:0] abs_mag(input logic signed [PW:0] x);
    logic [PW:0] t;
    t = x[PW] ? -x : x;
    return t[PW-1:0];
  endfunction

  // saturate sign and magnitude to the signed result range
  function automatic logic [W-1:0] sat_sm(input logic neg, input logic [PW-1:0] m);
    logic [W-1:0] r;
    if (!neg) begin
      r = (|m[PW-1:W-1]) ? {1'b0, {(W-1){1'b1}}} : m[W-1:0];
    end else if ((|m[PW-1:W]) || (m[W-1] && (|m[W-2:0]))) begin
      r = {1'b1, {(W-1){1'b0}}};
    end else begin
      r = -m[W-1:0];
    end
    return r;
  endfunction

  // saturate a sum with one guard bit
  function automatic logic [W-1:0] sat_sum(input logic signed [W:0] s);
    logic [W-1:0] r;
    if (s[W] != s[W-1]) begin
      r = s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      r = s[W-1:0];
    end
    return r;
  endfunction

  // stage one: products and sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op1_q <= op_e'(opcode_i);
      ac_q  <= $signed(a_re_i) * $signed(b_re_i);
      ad_q  <= $signed(a_re_i) * $signed(b_im_i);
      bc_q  <= $signed(a_im_i) * $signed(b_re_i);
      bd_q  <= $signed(a_im_i) * $signed(b_im_i);
      cc_q  <= $signed(b_re_i) * $signed(b_re_i);
      dd_q  <= $signed(b_im_i) * $signed(b_im_i);
      if (op_e'(opcode_i) == OP_SUB) begin
        sum_re_q <= $signed({a_re_i[W-1], a_re_i}) - $signed({b_re_i[W-1], b_re_i});
        sum_im_q <= $signed({a_im_i[W-1], a_im_i}) - $signed({b_im_i[W-1], b_im_i});
      end else begin
        sum_re_q <= $signed({a_re_i[W-1], a_re_i}) + $signed({b_re_i[W-1], b_re_i});
        sum_im_q <= $signed({a_im_i[W-1], a_im_i}) + $signed({b_im_i[W-1], b_im_i});
      end
    end
  end

  // stage two: product sums, rescaling and divide setup
  always_comb begin
    mre = $signed({ac_q[PW-1], ac_q}) - $signed({bd_q[PW-1], bd_q});
    mim = $signed({ad_q[PW-1], ad_q}) + $signed({bc_q[PW-1], bc_q});
    nre = $signed({ac_q[PW-1], ac_q}) + $signed({bd_q[PW-1], bd_q});
    nim = $signed({bc_q[PW-1], bc_q}) - $signed({ad_q[PW-1], ad_q});
    mul_re_mag = abs_mag(mre) >> F;
    mul_im_mag = abs_mag(mim) >> F;
    den_d      = cc_q[PW-1:0] + dd_q[PW-1:0];
    mag_re_d   = abs_mag(nre);
    mag_im_d   = abs_mag(nim);

    ctrl_d.vld    = vld1_q;
    ctrl_d.is_div = (op1_q == OP_DIV);
    ctrl_d.dz     = (op1_q == OP_DIV) && (den_d == '0);
    ctrl_d.neg_re = nre[PW];
    ctrl_d.neg_im = nim[PW];

    case (op1_q)
      OP_ADD, OP_SUB: begin
        res_re_d = sat_sum(sum_re_q);
        res_im_d = sat_sum(sum_im_q);
      end
      OP_MUL: begin
        res_re_d = sat_sm(mre[PW], mul_re_mag);
        res_im_d = sat_sm(mim[PW], mul_im_mag);
      end
      default: begin
        res_re_d = '0;
        res_im_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_re_q <= mag_re_d;
      mag_im_q <= mag_im_d;
      den_q    <= den_d;
      res_re_q <= res_re_d;
      res_im_q <= res_im_d;
    end
  end

  assign ctrl_o   = ctrl_q;
  assign mag_re_o = mag_re_q;
  assign mag_im_o = mag_im_q;
  assign den_o    = den_q;
  assign res_re_o = res_re_q;
  assign res_im_o = res_im_q;

endmodule

FILE: hdl/cau_div_cell.sv
// ---------------------------------------------------------------------------
// cau_div_cell: one restoring divide step for the real and imaginary lanes
// shifts in one dividend bit, subtracts the divisor if it fits and hands
// remainder, quotient and the item's other fields to the next cell
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cau_div_cell #(
  parameter int unsigned W  = cau_pkg::WidthDef,
  parameter int unsigned DW = 2 * cau_pkg::WidthDef + cau_pkg::FracDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  cau_pkg::ctrl_t   ctrl_i,
  input  logic [2*W-1:0]   den_i,
  input  logic [2*W-1:0]   rem_re_i,
  input  logic [2*W-1:0]   rem_im_i,
  input  logic [DW-1:0]    dvd_re_i,
  input  logic [DW-1:0]    dvd_im_i,
  input  logic [W-1:0]     q_re_i,
  input  logic [W-1:0]     q_im_i,
  input  logic             ovf_re_i,
  input  logic             ovf_im_i,
  input  logic [W-1:0]     res_re_i,
  input  logic [W-1:0]     res_im_i,
  output cau_pkg::ctrl_t   ctrl_o,
  output logic [2*W-1:0]   den_o,
  output logic [2*W-1:0]   rem_re_o,
  output logic [2*W-1:0]   rem_im_o,
  output logic [DW-1:0]    dvd_re_o,
  output logic [DW-1:0]    dvd_im_o,
  output logic [W-1:0]     q_re_o,
  output logic [W-1:0]     q_im_o,
  output logic             ovf_re_o,
  output logic             ovf_im_o,
  output logic [W-1:0]     res_re_o,
  output logic [W-1:0]     res_im_o
);
  import cau_pkg::*;

  localparam int unsigned PW = 2 * W;

  ctrl_t         ctrl_q;
  logic [PW-1:0] den_q, rem_re_q, rem_im_q, rem_re_d, rem_im_d;
  logic [DW-1:0] dvd_re_q, dvd_im_q;
  logic [W-1:0]  q_re_q, q_im_q, res_re_q, res_im_q;
  logic          ovf_re_q, ovf_im_q, bit_re, bit_im;
  logic [PW:0]   t_re, t_im;

  // trial subtract on both lanes
  always_comb begin
    t_re   = {rem_re_i, dvd_re_i[DW-1]};
    t_im   = {rem_im_i, dvd_im_i[DW-1]};
    bit_re = (t_re >= {1'b0, den_i});
    bit_im = (t_im >= {1'b0, den_i});
    rem_re_d = bit_re ? PW'(t_re - {1'b0, den_i}) : t_re[PW-1:0];
    rem_im_d = bit_im ? PW'(t_im - {1'b0, den_i}) : t_im[PW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  // quotient bits leaving the top of the window mark overflow
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q    <= den_i;
      rem_re_q <= rem_re_d;
      rem_im_q <= rem_im_d;
      dvd_re_q <= dvd_re_i << 1;
      dvd_im_q <= dvd_im_i << 1;
      q_re_q   <= {q_re_i[W-2:0], bit_re};
      q_im_q   <= {q_im_i[W-2:0], bit_im};
      ovf_re_q <= ovf_re_i | q_re_i[W-1];
      ovf_im_q <= ovf_im_i | q_im_i[W-1];
      res_re_q <= res_re_i;
      res_im_q <= res_im_i;
    end
  end

  assign ctrl_o   = ctrl_q;
  assign den_o    = den_q;
  assign rem_re_o = rem_re_q;
  assign rem_im_o = rem_im_q;
  assign dvd_re_o = dvd_re_q;
  assign dvd_im_o = dvd_im_q;
  assign q_re_o   = q_re_q;
  assign q_im_o   = q_im_q;
  assign ovf_re_o = ovf_re_q;
  assign ovf_im_o = ovf_im_q;
  assign res_re_o = res_re_q;
  assign res_im_o = res_im_q;

endmodule

FILE: hdl/cau_out.sv
// ---------------------------------------------------------------------------
// cau_out: result formatting and output buffering
// picks the divide quotient or the passed result, saturates, and holds the
// word in an output register backed by a one-word skid stage
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cau_out #(
  parameter int unsigned W = cau_pkg::WidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cau_pkg::ctrl_t                ctrl_i,
  input  logic [W-1:0]                  q_re_i,
  input  logic [W-1:0]                  q_im_i,
  input  logic                          ovf_re_i,
  input  logic                          ovf_im_i,
  input  logic [W-1:0]                  res_re_i,
  input  logic [W-1:0]                  res_im_i,
  output logic                          adv_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [((2*W+8)/8)*8-1:0]      m_axis_tdata
);
  import cau_pkg::*;

  localparam int unsigned OW = ((2 * W + 8) / 8) * 8;

  logic [OW-1:0] word_d, out_q, skid_q;
  logic          out_v_q, skid_v_q;
  logic [W-1:0]  re_d, im_d;
  logic          dz_d, in_v;

  // saturate an unsigned quotient with its sign
  function automatic logic [W-1:0] sat_q(input logic neg, input logic ovf,
                                         input logic [W-1:0] q);
    logic [W-1:0] r;
    if (!neg) begin
      r = (ovf || q[W-1]) ? {1'b0, {(W-1){1'b1}}} : q;
    end else if (ovf || (q[W-1] && (|q[W-2:0]))) begin
      r = {1'b1, {(W-1){1'b0}}};
    end else begin
      r = -q;
    end
    return r;
  endfunction

  // final result selection
  always_comb begin
    dz_d = ctrl_i.is_div & ctrl_i.dz;
    if (!ctrl_i.is_div) begin
      re_d = res_re_i;
      im_d = res_im_i;
    end else if (ctrl_i.dz) begin
      re_d = '0;
      im_d = '0;
    end else begin
      re_d = sat_q(ctrl_i.neg_re, ovf_re_i, q_re_i);
      im_d = sat_q(ctrl_i.neg_im, ovf_im_i, q_im_i);
    end
    word_d = OW'({dz_d, im_d, re_d});
  end

  assign adv_o = !skid_v_q;
  assign in_v  = ctrl_i.vld && adv_o;

  // output register with skid word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_v_q && !m_axis_tready) begin
      if (in_v) begin
        skid_v_q <= 1'b1;
      end
    end else if (skid_v_q) begin
      out_v_q  <= 1'b1;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q <= in_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_v_q && !m_axis_tready) begin
      if (in_v) begin
        skid_q <= word_d;
      end
    end else if (skid_v_q) begin
      out_q <= skid_q;
    end else if (in_v) begin
      out_q <= word_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

`ifndef NO_ASSERTIONS
  // the skid word is only used behind a held output word
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid word without output word");

  // the skid word fills only when the output was stalled
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !m_axis_tready))
    else $error("skid filled without stall");

  // a zero divisor word carries a zero result
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q[2*W]) |-> (out_q[2*W-1:0] == '0))
    else $error("zero divisor with nonzero result");
`endif

endmodule

FILE: hdl/complex_arith_unit.sv
// ---------------------------------------------------------------------------
// complex_arith_unit: complex add, subtract, multiply and divide
// signed fixed-point operands, pipelined with a chain of divide cells
// ---------------------------------------------------------------------------
// Usage:
//   The input stream carries one operation per word: opcode and two complex
//   operands. The output stream returns one word per input word, in order:
//   saturated real and imaginary parts and a divide-by-zero flag.
//   Each word passes two front-end stages for the products and sums, one
//   divide cell per quotient bit of the dividend, and the output register.
//   Every operation walks the full chain, so order is kept.
//   Throughput is one word per cycle while the skid word is empty; each
//   cell performs one restoring subtract step per lane and passes its item on.
//   s_axis_tready comes from a register: it drops only while the skid word
//   is occupied. When the receiver stalls, the output word holds, one more
//   word lands in the skid stage and the whole chain freezes until the
//   output is taken.
//   Reset clears all valid bits; the output stream is empty after reset and
//   the block accepts input as soon as reset is released.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module complex_arith_unit #(
  parameter int unsigned WIDTH     = cau_pkg::WidthDef,
  parameter int unsigned FRAC_BITS = cau_pkg::FracDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // opcode, a_re, a_im, b_re, b_im from bit 0 up
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [((4*WIDTH+9)/8)*8-1:0]     s_axis_tdata,
  // res_re, res_im, div_by_zero from bit 0 up
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [((2*WIDTH+8)/8)*8-1:0]     m_axis_tdata
);
  import cau_pkg::*;

  localparam int unsigned W  = WIDTH;
  localparam int unsigned PW = 2 * WIDTH;
  localparam int unsigned DW = 2 * WIDTH + FRAC_BITS;

  logic adv;

  // chain links, entry 0 from the front end
  ctrl_t         ctrl_w   [DW+1];
  logic [PW-1:0] den_w    [DW+1];
  logic [PW-1:0] rem_re_w [DW+1];
  logic [PW-1:0] rem_im_w [DW+1];
  logic [DW-1:0] dvd_re_w [DW+1];
  logic [DW-1:0] dvd_im_w [DW+1];
  logic [W-1:0]  q_re_w   [DW+1];
  logic [W-1:0]  q_im_w   [DW+1];
  logic          ovf_re_w [DW+1];
  logic          ovf_im_w [DW+1];
  logic [W-1:0]  res_re_w [DW+1];
  logic [W-1:0]  res_im_w [DW+1];
  logic [PW-1:0] mag_re, mag_im;

  // front end
  cau_prep #(.W(W), .F(FRAC_BITS)) u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .vld_i    (s_axis_tvalid),
    .opcode_i (s_axis_tdata[1:0]),
    .a_re_i   (s_axis_tdata[2+W-1:2]),
    .a_im_i   (s_axis_tdata[2+2*W-1:2+W]),
    .b_re_i   (s_axis_tdata[2+3*W-1:2+2*W]),
    .b_im_i   (s_axis_tdata[2+4*W-1:2+3*W]),
    .ctrl_o   (ctrl_w[0]),
    .mag_re_o (mag_re),
    .mag_im_o (mag_im),
    .den_o    (den_w[0]),
    .res_re_o (res_re_w[0]),
    .res_im_o (res_im_w[0])
  );

  // divide chain start: empty remainder, scaled dividend
  assign rem_re_w[0] = '0;
  assign rem_im_w[0] = '0;
  assign dvd_re_w[0] = DW'(mag_re) << FRAC_BITS;
  assign dvd_im_w[0] = DW'(mag_im) << FRAC_BITS;
  assign q_re_w[0]   = '0;
  assign q_im_w[0]   = '0;
  assign ovf_re_w[0] = 1'b0;
  assign ovf_im_w[0] = 1'b0;

  // row of divide cells
  for (genvar i = 0; i < DW; i++) begin : g_cell
    cau_div_cell #(.W(W), .DW(DW)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (adv),
      .ctrl_i   (ctrl_w[i]),
      .den_i    (den_w[i]),
      .rem_re_i (rem_re_w[i]),
      .rem_im_i (rem_im_w[i]),
      .dvd_re_i (dvd_re_w[i]),
      .dvd_im_i (dvd_im_w[i]),
      .q_re_i   (q_re_w[i]),
      .q_im_i   (q_im_w[i]),
      .ovf_re_i (ovf_re_w[i]),
      .ovf_im_i (ovf_im_w[i]),
      .res_re_i (res_re_w[i]),
      .res_im_i (res_im_w[i]),
      .ctrl_o   (ctrl_w[i+1]),
      .den_o    (den_w[i+1]),
      .rem_re_o (rem_re_w[i+1]),
      .rem_im_o (rem_im_w[i+1]),
      .dvd_re_o (dvd_re_w[i+1]),
      .dvd_im_o (dvd_im_w[i+1]),
      .q_re_o   (q_re_w[i+1]),
      .q_im_o   (q_im_w[i+1]),
      .ovf_re_o (ovf_re_w[i+1]),
      .ovf_im_o (ovf_im_w[i+1]),
      .res_re_o (res_re_w[i+1]),
      .res_im_o (res_im_w[i+1])
    );
  end

  // result formatting and output buffer
  cau_out #(.W(W)) u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl_w[DW]),
    .q_re_i        (q_re_w[DW]),
    .q_im_i        (q_im_w[DW]),
    .ovf_re_i      (ovf_re_w[DW]),
    .ovf_im_i      (ovf_im_w[DW]),
    .res_re_i      (res_re_w[DW]),
    .res_im_i      (res_im_w[DW]),
    .adv_o         (adv),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  assign s_axis_tready = adv;

endmodule

FILE: tb/sv/complex_arith_unit_tb.sv
// ---------------------------------------------------------------------------
// complex_arith_unit_tb: self-checking bench for the complex arithmetic unit
// directed table of corner operations, then random words with random gaps
// on both streams; every output word is checked against its table entry or a local predictor
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module complex_arith_unit_tb;
  import cau_pkg::*;

  localparam int unsigned W     = 16;
  localparam int unsigned FB    = 8;
  localparam int unsigned IN_W  = ((4*W+9)/8)*8;
  localparam int unsigned OUT_W = ((2*W+8)/8)*8;
  localparam int unsigned LAT   = 2*W + FB + 3;
  localparam int unsigned N_RAND = 1900;

  typedef struct packed {
    logic [W-1:0] re;
    logic [W-1:0] im;
    logic         dz;
  } cplx_res_t;

  typedef struct {
    op_e           op;
    logic [W-1:0]  ar, ai, br, bi;
    bit            known;
    cplx_res_t     res;
  } stim_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;

  cplx_res_t res_fifo[$];
  int        n_err;
  bit        hold_long;

  complex_arith_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // saturate a signed wide value to the part width
  function automatic logic [W-1:0] sat_part(longint v);
    longint hi, lo;
    hi = (64'sd1 <<< (W-1)) - 1;
    lo = -(64'sd1 <<< (W-1));
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[W-1:0];
  endfunction

  // |num| * 2^FB / den truncated toward zero, sign of num
  function automatic longint quot_trunc(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag / den) * (64'sd1 <<< FB) + ((mag % den) * (64'sd1 <<< FB)) / den;
    return (num < 0) ? -q : q;
  endfunction

  // expected word of one complex operation
  function automatic cplx_res_t complex_predict(op_e op, logic [W-1:0] ar,
                                                logic [W-1:0] ai,
                                                logic [W-1:0] br,
                                                logic [W-1:0] bi);
    longint a, b, c, d, re, im, den, mr, mi;
    cplx_res_t r;
    a = longint'($signed(ar)); b = longint'($signed(ai));
    c = longint'($signed(br)); d = longint'($signed(bi));
    r.dz = 1'b0;
    re = 0; im = 0;
    case (op)
      OP_ADD: begin re = a + c; im = b + d; end
      OP_SUB: begin re = a - c; im = b - d; end
      OP_MUL: begin
        re = a*c - b*d;
        im = a*d + b*c;
        mr = ((re < 0) ? -re : re) >> FB;
        mi = ((im < 0) ? -im : im) >> FB;
        re = (re < 0) ? -mr : mr;
        im = (im < 0) ? -mi : mi;
      end
      default: begin
        den = c*c + d*d;
        if (den == 0) r.dz = 1'b1;
        else begin
          re = quot_trunc(a*c + b*d, den);
          im = quot_trunc(b*c - a*d, den);
        end
      end
    endcase
    r.re = sat_part(re);
    r.im = sat_part(im);
    return r;
  endfunction

  // directed table
  localparam logic [W-1:0] MAXP = 16'h7fff, MINN = 16'h8000, ONE = 16'h0100;
  stim_row_t dir_tab[] = '{
    '{OP_ADD, 16'h0, 16'h0, 16'h0, 16'h0, 1, '{16'h0, 16'h0, 1'b0}},
    '{OP_ADD, MAXP, MINN, MAXP, MINN, 1, '{MAXP, MINN, 1'b0}},
    '{OP_ADD, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 0, '0},
    '{OP_SUB, MINN, MAXP, MAXP, MINN, 1, '{MINN, MAXP, 1'b0}},
    '{OP_SUB, MAXP, MAXP, MAXP, MAXP, 1, '{16'h0, 16'h0, 1'b0}},
    '{OP_MUL, MINN, MINN, MINN, MINN, 0, '0},
    '{OP_MUL, MAXP, MAXP, MAXP, MAXP, 0, '0},
    '{OP_MUL, MINN, MAXP, MAXP, MINN, 0, '0},
    '{OP_MUL, ONE, 16'h0, 16'h1234, 16'hedcb, 0, '0},
    '{OP_MUL, 16'hffff, 16'h0001, 16'h0001, 16'h0001, 0, '0},
    '{OP_DIV, MAXP, MINN, 16'h0, 16'h0, 1, '{16'h0, 16'h0, 1'b1}},
    '{OP_DIV, 16'h0, 16'h0, 16'h0, 16'h0, 1, '{16'h0, 16'h0, 1'b1}},
    '{OP_DIV, MAXP, MAXP, 16'h0001, 16'h0, 1, '{MAXP, MAXP, 1'b0}},
    '{OP_DIV, MINN, MINN, 16'h0001, 16'h0001, 0, '0},
    '{OP_DIV, MINN, MINN, MINN, MINN, 0, '0},
    '{OP_DIV, ONE, 16'h0, 16'h0, ONE, 0, '0},
    '{OP_DIV, 16'h0003, 16'hfffd, 16'h0007, 16'h0002, 0, '0},
    '{OP_DIV, 16'h0, 16'h0, 16'h0, MINN, 0, '0},
    '{OP_DIV, MAXP, 16'h0, MAXP, MAXP, 0, '0},
    '{OP_MUL, 16'h0, 16'h0, MAXP, MINN, 0, '0}
  };

  // send one word once the block takes it, with a random gap first unless no_gap is set
  task automatic send_word(op_e op, logic [W-1:0] ar, logic [W-1:0] ai,
                           logic [W-1:0] br, logic [W-1:0] bi,
                           bit known, cplx_res_t kres, bit no_gap);
    int gap;
    cplx_res_t p;
    gap = no_gap ? 0 : (($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                    : $urandom_range(0, 2));
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    p = complex_predict(op, ar, ai, br, bi);
    if (known && p !== kres)
      $display("%0t predictor disagrees with table: %h vs %h", $time, p, kres);
    res_fifo.push_back(known ? kres : p);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_W-4*W-2){1'b0}}, bi, br, ai, ar, op};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic logic [W-1:0] rand_part();
    case ($urandom_range(0, 7))
      0: return MAXP;
      1: return MINN;
      2: return '0;
      3: return W'($signed($urandom_range(0, 1023)) - 512);
      default: return W'($urandom);
    endcase
  endfunction

  // stimulus
  initial begin
    op_e op;
    logic [W-1:0] br, bi;
    int wait_n;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    hold_long = 1'b0;
    n_err = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_tab[i])
      send_word(dir_tab[i].op, dir_tab[i].ar, dir_tab[i].ai, dir_tab[i].br,
                dir_tab[i].bi, dir_tab[i].known, dir_tab[i].res, 1'b0);
    for (int i = 0; i < N_RAND; i++) begin
      if (i == 300) hold_long = 1'b1;
      op = op_e'($urandom_range(0, 3));
      br = rand_part();
      bi = rand_part();
      if (op == OP_DIV && $urandom_range(0, 19) == 0) begin
        br = '0; bi = '0;
      end
      // back-to-back bursts, one of them while the receiver holds off
      send_word(op, rand_part(), rand_part(), br, bi, 1'b0, '0,
                (i >= 300 && i < 420) || (i % 200) < 30);
    end
    s_axis_tvalid <= 1'b0;
    wait_n = 0;
    while (res_fifo.size() != 0 && wait_n < 200000) begin
      @(posedge clk_i);
      wait_n++;
    end
    repeat (LAT + 10) @(posedge clk_i);
    if (n_err == 0 && res_fifo.size() == 0 && !m_axis_tvalid)
      $display("complex_arith_unit regression: pass");
    else
      $display("complex_arith_unit regression: fail");
    $finish;
  end

  // receiver stalls, with one long hold-off while the sender keeps going
  initial begin
    int n;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_long) begin
        hold_long = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (150) @(posedge clk_i);
      end
      n = $urandom_range(0, 3);
      if (n == 0) begin
        m_axis_tready <= 1'b0;
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : 1)
          @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  // output check
  always @(posedge clk_i) begin
    cplx_res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[2*W:0] == m_axis_tdata[2*W:0] ?
            '{m_axis_tdata[W-1:0], m_axis_tdata[2*W-1:W], m_axis_tdata[2*W]} : '0;
      if (res_fifo.size() == 0) begin
        $display("%0t unexpected word %h", $time, got);
        n_err++;
      end else begin
        want = res_fifo.pop_front();
        if (got.re !== want.re) begin
          $display("%0t res_re exp %h got %h", $time, want.re, got.re);
          n_err++;
        end
        if (got.im !== want.im) begin
          $display("%0t res_im exp %h got %h", $time, want.im, got.im);
          n_err++;
        end
        if (got.dz !== want.dz) begin
          $display("%0t div_by_zero exp %b got %b", $time, want.dz, got.dz);
          n_err++;
        end
      end
    end
  end

  // run limit
  initial begin
    #5ms;
    $display("complex_arith_unit regression: fail");
    $finish;
  end

endmodule
